// ===== sv/idv_pkg.sv =====
package idv_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned FIELD_W = 7;

	localparam logic [POS_W-1:0] POS_YEAR_LO = 4'd2;
	localparam logic [POS_W-1:0] POS_DASH_A  = 4'd4;
	localparam logic [POS_W-1:0] POS_DASH_B  = 4'd7;
	localparam logic [POS_W-1:0] POS_LAST    = 4'd9;
	localparam logic [POS_W-1:0] DATE_LEN    = 4'd10;

	localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

	localparam logic [FIELD_W-1:0] MONTH_FEB = 7'd2;
	localparam logic [FIELD_W-1:0] MONTH_APR = 7'd4;
	localparam logic [FIELD_W-1:0] MONTH_JUN = 7'd6;
	localparam logic [FIELD_W-1:0] MONTH_SEP = 7'd9;
	localparam logic [FIELD_W-1:0] MONTH_NOV = 7'd11;
	localparam logic [FIELD_W-1:0] MONTH_MAX = 7'd12;
	localparam logic [FIELD_W-1:0] DAY_MAX   = 7'd31;
	localparam logic [FIELD_W-1:0] DAY_FEB   = 7'd29;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              string_start;
	} char_beat_t;

	typedef struct packed {
		logic               date_valid;
		logic [YEAR_W-1:0]  year_value;
		logic [FIELD_W-1:0] month_value;
		logic [FIELD_W-1:0] day_value;
	} date_result_t;

endpackage

// ===== sv/idv_char_if.sv =====
interface idv_char_if;
	logic                        valid;
	logic                        ready;
	logic [idv_pkg::CHAR_W-1:0]  char_code;
	logic                        string_start;

	modport source (output valid, output char_code, output string_start, input ready);
	modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

// ===== sv/idv_result_if.sv =====
interface idv_result_if;
	logic                         valid;
	logic                         ready;
	logic                         date_valid;
	logic [idv_pkg::YEAR_W-1:0]   year_value;
	logic [idv_pkg::FIELD_W-1:0]  month_value;
	logic [idv_pkg::FIELD_W-1:0]  day_value;

	modport source (output valid, output date_valid, output year_value,
		output month_value, output day_value, input ready);
	modport sink   (input valid, input date_valid, input year_value,
		input month_value, input day_value, output ready);
endinterface

// ===== sv/idv_in_reg.sv =====
module idv_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	idv_char_if.sink            chars,
	input  logic                advance,
	output logic                beat_valid,
	output idv_pkg::char_beat_t beat
);

	logic                valid_s1;
	idv_pkg::char_beat_t beat_s1;

	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			beat_s1.char_code    <= chars.char_code;
			beat_s1.string_start <= chars.string_start;
		end
	end

	assign beat_valid = valid_s1;
	assign beat       = beat_s1;

endmodule

// ===== sv/idv_parse.sv =====
module idv_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beat_valid,
	input  idv_pkg::char_beat_t beat,
	output logic                advance,
	idv_result_if.source        dates
);

	function automatic logic calendar_ok(
		input logic [idv_pkg::YEAR_W-1:0]  y,
		input logic [idv_pkg::FIELD_W-1:0] m,
		input logic [idv_pkg::FIELD_W-1:0] d,
		input logic                        leap
	);
		logic ok;
		ok = (y != '0) && (m != '0) && (d != '0);
		if (m > idv_pkg::MONTH_MAX || d > idv_pkg::DAY_MAX)
			ok = 1'b0;
		if (d == idv_pkg::DAY_MAX && (m == idv_pkg::MONTH_APR || m == idv_pkg::MONTH_JUN
				|| m == idv_pkg::MONTH_SEP || m == idv_pkg::MONTH_NOV))
			ok = 1'b0;
		if (m == idv_pkg::MONTH_FEB) begin
			if (d > idv_pkg::DAY_FEB)
				ok = 1'b0;
			if (d == idv_pkg::DAY_FEB && !leap)
				ok = 1'b0;
		end
		return ok;
	endfunction

	// year_hi/year_lo hold the first and last digit pairs for the leap test
	logic [idv_pkg::POS_W-1:0]   pos_q;
	logic [idv_pkg::YEAR_W-1:0]  year_q;
	logic [idv_pkg::FIELD_W-1:0] year_hi_q;
	logic [idv_pkg::FIELD_W-1:0] year_lo_q;
	logic [idv_pkg::FIELD_W-1:0] month_q;
	logic [idv_pkg::FIELD_W-1:0] day_q;
	logic                        err_q;

	logic [idv_pkg::POS_W-1:0]   pos_b, pos_n;
	logic [idv_pkg::YEAR_W-1:0]  year_b, year_n;
	logic [idv_pkg::FIELD_W-1:0] hi_b, hi_n, lo_b, lo_n, month_b, month_n, day_b, day_n;
	logic                        err_b, err_n;
	logic                        digit, active, produce, leap;
	logic [idv_pkg::FIELD_W-1:0] dv;

	logic                        valid_s2;
	idv_pkg::date_result_t       res_s2, res_n;

	always_comb begin
		pos_b   = beat.string_start ? '0 : pos_q;
		year_b  = beat.string_start ? '0 : year_q;
		hi_b    = beat.string_start ? '0 : year_hi_q;
		lo_b    = beat.string_start ? '0 : year_lo_q;
		month_b = beat.string_start ? '0 : month_q;
		day_b   = beat.string_start ? '0 : day_q;
		err_b   = beat.string_start ? 1'b0 : err_q;

		digit  = (beat.char_code >= idv_pkg::CHAR_DIGIT_0)
			&& (beat.char_code <= idv_pkg::CHAR_DIGIT_9);
		dv     = {3'b000, beat.char_code[3:0]};
		active = pos_b < idv_pkg::DATE_LEN;

		pos_n   = pos_b;
		year_n  = year_b;
		hi_n    = hi_b;
		lo_n    = lo_b;
		month_n = month_b;
		day_n   = day_b;
		err_n   = err_b;

		if (active) begin
			pos_n = pos_b + 4'd1;
			if (pos_b == idv_pkg::POS_DASH_A || pos_b == idv_pkg::POS_DASH_B) begin
				if (beat.char_code != idv_pkg::CHAR_DASH)
					err_n = 1'b1;
			end else if (!digit) begin
				err_n = 1'b1;
			end else if (pos_b < idv_pkg::POS_DASH_A) begin
				year_n = {year_b[10:0], 3'b000} + {year_b[12:0], 1'b0}
					+ {7'd0, dv};
				if (pos_b < idv_pkg::POS_YEAR_LO)
					hi_n = {hi_b[3:0], 3'b000} + {hi_b[5:0], 1'b0} + dv;
				else
					lo_n = {lo_b[3:0], 3'b000} + {lo_b[5:0], 1'b0} + dv;
			end else if (pos_b < idv_pkg::POS_DASH_B) begin
				month_n = {month_b[3:0], 3'b000} + {month_b[5:0], 1'b0} + dv;
			end else begin
				day_n = {day_b[3:0], 3'b000} + {day_b[5:0], 1'b0} + dv;
			end
		end

		// year = 100*hi + lo, and 100 is a multiple of 4
		leap = (lo_n[1:0] == 2'b00) && ((lo_n != '0) || (hi_n[1:0] == 2'b00));

		produce = beat_valid && (pos_b == idv_pkg::POS_LAST);

		if (err_n) begin
			res_n = '0;
		end else begin
			res_n.date_valid  = calendar_ok(year_n, month_n, day_n, leap);
			res_n.year_value  = year_n;
			res_n.month_value = month_n;
			res_n.day_value   = day_n;
		end
	end

	// hold the current beat while a finished result still waits
	assign advance = !(produce && valid_s2 && !dates.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			year_q    <= '0;
			year_hi_q <= '0;
			year_lo_q <= '0;
			month_q   <= '0;
			day_q     <= '0;
			err_q     <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (beat_valid && advance) begin
				pos_q     <= pos_n;
				year_q    <= year_n;
				year_hi_q <= hi_n;
				year_lo_q <= lo_n;
				month_q   <= month_n;
				day_q     <= day_n;
				err_q     <= err_n;
			end
			if (produce && advance)
				valid_s2 <= 1'b1;
			else if (dates.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce && advance)
			res_s2 <= res_n;
	end

	assign dates.valid       = valid_s2;
	assign dates.date_valid  = res_s2.date_valid;
	assign dates.year_value  = res_s2.year_value;
	assign dates.month_value = res_s2.month_value;
	assign dates.day_value   = res_s2.day_value;

endmodule

// ===== sv/iso_date_string_validator_top.sv =====
// YYYY-MM-DD date string checker.
// chars: one ASCII character per beat; string_start marks the first
// character of a string and restarts parsing, dropping any unfinished string.
// After reset the block sits at the first position, so no start mark is needed.
// dates: one beat per ten-character string, with date_valid and the parsed
// year, month and day; the fields read zero when the format is broken.
// Characters past the tenth are ignored until the next start mark.
// Flow: one character per cycle while chars.ready is high. A character sits in the input
// register while the position counter and digit accumulators update from it; the tenth
// character's result is then captured in the result register and offered on dates.
// When dates stalls, a waiting result holds its register; chars.ready drops
// only when the tenth character of the next string reaches the parser while
// that result is still unclaimed.
// Reset clears the position, accumulators, error flag and both valid bits.
module iso_date_string_validator_top (
	input  logic         clk,
	input  logic         arst_n,
	idv_char_if.sink     chars,
	idv_result_if.source dates
);

	logic                beat_valid;
	logic                advance;
	idv_pkg::char_beat_t beat;

	idv_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.advance    (advance),
		.beat_valid (beat_valid),
		.beat       (beat)
	);

	idv_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat       (beat),
		.advance    (advance),
		.dates      (dates)
	);

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		dates.valid && dates.date_valid |-> dates.month_value != '0
			&& dates.month_value <= idv_pkg::MONTH_MAX && dates.day_value != '0
			&& dates.day_value <= idv_pkg::DAY_MAX && dates.year_value != '0)
		else $error("accepted date out of calendar range");

	a_feb_day: assert property (@(posedge clk) disable iff (!arst_n)
		dates.valid && dates.date_valid && dates.month_value == idv_pkg::MONTH_FEB
			|-> dates.day_value <= idv_pkg::DAY_FEB)
		else $error("February day above limit reported valid");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> dates.valid && !dates.ready)
		else $error("input stalled without output backpressure");

	a_format_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dates.valid && dates.year_value == '0 |-> !dates.date_valid)
		else $error("zero year reported valid");

endmodule

// ===== tb/iso_date_string_validator_top_tb.sv =====
module iso_date_string_validator_top_tb;
	import idv_pkg::*;

	localparam int unsigned RANDOM_CHARS = 1650;
	localparam int unsigned QUIET_LIMIT  = 3000;
	localparam int unsigned DATES_HOLD   = 300;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned TEXT_W       = 80;

	typedef struct packed {
		logic [TEXT_W-1:0] text;
		logic [POS_W-1:0]  len;
		logic              start;
		logic              typed;
		date_result_t      want;
	} char_row_t;

	logic clk;
	logic arst_n;

	idv_char_if   chars ();
	idv_result_if dates ();

	iso_date_string_validator_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.dates  (dates)
	);

	// parser state mirrored from the block
	logic [POS_W-1:0]   pos_q;
	logic [YEAR_W-1:0]  year_q;
	logic [FIELD_W-1:0] month_q;
	logic [FIELD_W-1:0] day_q;
	logic               bad_format_q;

	date_result_t expected_dates [$];
	char_row_t    dir_rows [5];
	int unsigned  mismatches;
	int unsigned  chars_counted;
	int unsigned  chars_idle_pct;
	int unsigned  dates_idle_pct;
	bit           dates_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit leap_year(input logic [YEAR_W-1:0] y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic bit real_date(input logic [YEAR_W-1:0] y,
			input logic [FIELD_W-1:0] m, input logic [FIELD_W-1:0] d);
		if (y == 0 || m == 0 || d == 0)
			return 1'b0;
		if (m > MONTH_MAX || d > DAY_MAX)
			return 1'b0;
		if (d == DAY_MAX && (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
				m == MONTH_NOV))
			return 1'b0;
		if (m == MONTH_FEB && (d > DAY_FEB || (d == DAY_FEB && !leap_year(y))))
			return 1'b0;
		return 1'b1;
	endfunction

	// Advance the mirrored parser by one character; returns 1 when a date completes.
	function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic s,
			output bit consumed, output date_result_t res);
		logic [3:0] dv;
		bit         is_digit;
		res = '0;
		if (s) begin
			pos_q        = '0;
			year_q       = '0;
			month_q      = '0;
			day_q        = '0;
			bad_format_q = 1'b0;
		end
		consumed = (pos_q < DATE_LEN);
		if (!consumed)
			return 1'b0;
		is_digit = (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9);
		dv = 4'(c - CHAR_DIGIT_0);
		if (pos_q == POS_DASH_A || pos_q == POS_DASH_B) begin
			if (c != CHAR_DASH)
				bad_format_q = 1'b1;
		end else if (!is_digit) begin
			// latch the error, leave the accumulator alone
			bad_format_q = 1'b1;
		end else if (pos_q < POS_DASH_A) begin
			year_q = YEAR_W'(year_q * 10 + dv);
		end else if (pos_q < POS_DASH_B) begin
			month_q = FIELD_W'(month_q * 10 + dv);
		end else begin
			day_q = FIELD_W'(day_q * 10 + dv);
		end
		pos_q = pos_q + 1'b1;
		if (pos_q != DATE_LEN)
			return 1'b0;
		if (!bad_format_q) begin
			res.date_valid  = real_date(year_q, month_q, day_q);
			res.year_value  = year_q;
			res.month_value = month_q;
			res.day_value   = day_q;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input date_result_t want,
			input date_result_t got);
		mismatches++;
		$display("%0t %s: expected %0d %0d-%0d-%0d, got %0d %0d-%0d-%0d", $time, what,
			want.date_valid, want.year_value, want.month_value, want.day_value,
			got.date_valid, got.year_value, got.month_value, got.day_value);
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic s,
			input bit typed = 1'b0, input date_result_t want = '0);
		date_result_t res;
		bit           consumed;
		while ($urandom_range(99) < chars_idle_pct) begin
			chars.valid <= 1'b0;
			@(posedge clk);
		end
		chars.valid        <= 1'b1;
		chars.char_code    <= c;
		chars.string_start <= s;
		do
			@(posedge clk);
		while (!chars.ready);
		if (parse_char(c, s, consumed, res))
			expected_dates.insert(expected_dates.size(), typed ? want : res);
		if (consumed)
			chars_counted++;
	endtask

	task automatic send_random_string();
		logic [CHAR_W-1:0]  text [10];
		logic [YEAR_W-1:0]  y;
		logic [FIELD_W-1:0] m;
		logic [FIELD_W-1:0] d;
		int unsigned        kind;
		int unsigned        len;
		int unsigned        spot;
		bit                 first_start;
		bit                 scatter;
		case ($urandom_range(4))
			0: y = YEAR_W'($urandom_range(9999));
			1: y = YEAR_W'($urandom_range(2499) * 4);
			2: y = YEAR_W'($urandom_range(99) * 100);
			3: y = YEAR_W'($urandom_range(24) * 400);
			default: y = $urandom_range(1) ? YEAR_W'(9999) : '0;
		endcase
		m = ($urandom_range(4) == 0) ? FIELD_W'($urandom_range(99)) :
			FIELD_W'($urandom_range(1, 12));
		if ($urandom_range(3) == 0)
			m = MONTH_FEB;
		case ($urandom_range(3))
			0: d = FIELD_W'($urandom_range(28, 31));
			1: d = FIELD_W'($urandom_range(1, 31));
			2: d = FIELD_W'($urandom_range(99));
			default: d = FIELD_W'($urandom_range(1, 28));
		endcase
		text[0] = CHAR_DIGIT_0 + CHAR_W'(y / 1000);
		text[1] = CHAR_DIGIT_0 + CHAR_W'((y / 100) % 10);
		text[2] = CHAR_DIGIT_0 + CHAR_W'((y / 10) % 10);
		text[3] = CHAR_DIGIT_0 + CHAR_W'(y % 10);
		text[4] = CHAR_DASH;
		text[5] = CHAR_DIGIT_0 + CHAR_W'(m / 10);
		text[6] = CHAR_DIGIT_0 + CHAR_W'(m % 10);
		text[7] = CHAR_DASH;
		text[8] = CHAR_DIGIT_0 + CHAR_W'(d / 10);
		text[9] = CHAR_DIGIT_0 + CHAR_W'(d % 10);
		len         = 10;
		first_start = 1'b1;
		scatter     = 1'b0;
		kind        = $urandom_range(99);
		if (kind >= 62 && kind < 77) begin
			spot = $urandom_range(9);
			case ($urandom_range(3))
				0: text[spot] = CHAR_W'($urandom_range(255));
				1: text[spot] = CHAR_DASH;
				2: text[spot] = CHAR_DIGIT_0 + CHAR_W'($urandom_range(9));
				default: text[spot] = $urandom_range(1) ? CHAR_DIGIT_0 - 1'b1 :
					CHAR_DIGIT_9 + 1'b1;
			endcase
		end else if (kind >= 77 && kind < 87) begin
			len = $urandom_range(1, 9);
		end else if (kind >= 87 && kind < 94) begin
			for (int i = 0; i < 10; i++)
				text[i] = CHAR_W'($urandom_range(255));
			scatter = 1'b1;
		end else if (kind >= 94) begin
			first_start = 1'b0;
		end
		for (int i = 0; i < len; i++)
			send_char(text[i], (i == 0) ? first_start : (scatter && $urandom_range(15) == 0));
		// trailing bytes are dropped by the block when they follow a full ten-character string
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 3))
				send_char(CHAR_W'($urandom_range(255)), 1'b0);
	endtask

	task automatic wait_dates_drained();
		chars.valid <= 1'b0;
		wait (expected_dates.size() == 0);
		@(posedge clk);
	endtask

	// result side: check, then pick next ready
	initial begin
		int unsigned  hold_left;
		date_result_t want;
		date_result_t got;
		hold_left = 0;
		dates.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (dates.valid && dates.ready) begin
				got.date_valid  = dates.date_valid;
				got.year_value  = dates.year_value;
				got.month_value = dates.month_value;
				got.day_value   = dates.day_value;
				if (expected_dates.size() == 0) begin
					report_mismatch("unexpected date beat", '0, got);
				end else begin
					want = expected_dates.pop_front();
					if (got.date_valid !== want.date_valid ||
							got.year_value !== want.year_value ||
							got.month_value !== want.month_value ||
							got.day_value !== want.day_value)
						report_mismatch("wrong date beat", want, got);
				end
			end
			if (dates_hold_req) begin
				hold_left      = DATES_HOLD;
				dates_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				dates.ready <= 1'b0;
			end else begin
				dates.ready <= ($urandom_range(99) >= dates_idle_pct);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((chars.valid && chars.ready) || (dates.valid && dates.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("iso_date_string_validator_top: mismatch");
		$finish;
	end

	initial begin
		arst_n             <= 1'b0;
		chars.valid        <= 1'b0;
		chars.char_code    <= '0;
		chars.string_start <= 1'b0;
		pos_q          = '0;
		year_q         = '0;
		month_q        = '0;
		day_q          = '0;
		bad_format_q   = 1'b0;
		mismatches     = 0;
		chars_counted  = 0;
		dates_hold_req = 1'b0;
		chars_idle_pct = 6;
		dates_idle_pct = 45;

		// first string needs no start mark; stray byte after it is dropped;
		// a start mark abandons a partial string; broken format reads zero
		dir_rows[0] = '{"2000-02-29", 4'd10, 1'b0, 1'b1, '{1'b1, 14'd2000, 7'd2, 7'd29}};
		dir_rows[1] = '{"~",          4'd1,  1'b0, 1'b0, '0};
		dir_rows[2] = '{"1",          4'd1,  1'b1, 1'b0, '0};
		dir_rows[3] = '{"9999-12-31", 4'd10, 1'b1, 1'b1, '{1'b1, 14'd9999, 7'd12, 7'd31}};
		dir_rows[4] = '{"0000-00-0:", 4'd10, 1'b1, 1'b1, '0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			for (int i = 0; i < dir_rows[r].len; i++)
				send_char(dir_rows[r].text[8 * (dir_rows[r].len - 1 - i) +: 8],
					dir_rows[r].start && i == 0, dir_rows[r].typed, dir_rows[r].want);

		chars_counted = 0;
		while (chars_counted < RANDOM_CHARS / 3)
			send_random_string();

		wait_dates_drained();
		chars_idle_pct = 45;
		dates_idle_pct = 6;
		while (chars_counted < 2 * RANDOM_CHARS / 3)
			send_random_string();

		// hold off the result side while characters keep coming
		wait_dates_drained();
		chars_idle_pct = 0;
		dates_idle_pct = 0;
		dates_hold_req = 1'b1;
		while (chars_counted < RANDOM_CHARS)
			send_random_string();

		chars.valid <= 1'b0;
		wait (expected_dates.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("iso_date_string_validator_top: match");
		else
			$display("iso_date_string_validator_top: mismatch");
		$finish;
	end

endmodule
